@@ rtl/pa_pkg.sv @@
package pa_pkg;

  // Default width of a vertex handle
  localparam int unsigned TAG_BITS = 16;

  localparam int unsigned OP_BITS   = 2;
  localparam int unsigned MODE_BITS = 3;

  // Operation codes of an input beat
  localparam logic [OP_BITS-1:0] OP_VERTEX = 2'd0;
  localparam logic [OP_BITS-1:0] OP_BEGIN  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_END    = 2'd2;

  // Primitive modes; the two codes above QUAD_CHAIN act as none
  localparam logic [MODE_BITS-1:0] MODE_NONE  = 3'd0;
  localparam logic [MODE_BITS-1:0] TRIANGLES  = 3'd1;
  localparam logic [MODE_BITS-1:0] TRI_STRIP  = 3'd2;
  localparam logic [MODE_BITS-1:0] TRI_FAN    = 3'd3;
  localparam logic [MODE_BITS-1:0] QUADS      = 3'd4;
  localparam logic [MODE_BITS-1:0] QUAD_CHAIN = 3'd5;

  // Vertex slot cache
  localparam int unsigned SLOT_COUNT    = 4;
  localparam int unsigned SLOT_IDX_BITS = $clog2(SLOT_COUNT);

  // Depth of the run queue between front and back
  localparam int unsigned RUN_DEPTH = 4;

endpackage

@@ rtl/pa_if.sv @@
interface pa_vtx_if #(
  parameter int unsigned TAG_BITS = pa_pkg::TAG_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic [pa_pkg::OP_BITS-1:0]   op;
  logic [pa_pkg::MODE_BITS-1:0] prim_type;
  logic [TAG_BITS-1:0]          vertex_tag;

  modport source (output valid, op, prim_type, vertex_tag, input ready);
  modport sink   (input valid, op, prim_type, vertex_tag, output ready);
endinterface

interface pa_tri_if #(
  parameter int unsigned TAG_BITS = pa_pkg::TAG_BITS
) ();
  logic                valid;
  logic                ready;
  logic [TAG_BITS-1:0] corner_a;
  logic [TAG_BITS-1:0] corner_b;
  logic [TAG_BITS-1:0] corner_c;
  logic                last_of_run;

  modport source (output valid, corner_a, corner_b, corner_c, last_of_run, input ready);
  modport sink   (input valid, corner_a, corner_b, corner_c, last_of_run, output ready);
endinterface

@@ rtl/pa_front.sv @@
module pa_front #(
  parameter int unsigned TAG_BITS = pa_pkg::TAG_BITS,
  localparam int unsigned RUN_W   = 6 * TAG_BITS + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pa_vtx_if.sink          vtx_i,
  input  logic            run_full_i,
  output logic            run_push_o,
  output logic [RUN_W-1:0] run_data_o
);

  localparam int unsigned IW = pa_pkg::SLOT_IDX_BITS;

  logic [TAG_BITS-1:0]          slot_q [pa_pkg::SLOT_COUNT];
  logic [TAG_BITS-1:0]          slot_d [pa_pkg::SLOT_COUNT];
  logic [IW-1:0]                idx_q, idx_d;
  logic                         par_q, par_d;
  logic [pa_pkg::MODE_BITS-1:0] mode_q, mode_d;

  logic                accept;
  logic                emit, two;
  logic [TAG_BITS-1:0] w [pa_pkg::SLOT_COUNT];
  logic [TAG_BITS-1:0] t0a, t0b, t0c, t1a, t1b, t1c;
  logic [TAG_BITS-1:0] tmp;

  assign vtx_i.ready = !run_full_i;
  assign accept      = vtx_i.valid && vtx_i.ready;

  always_comb begin
    slot_d = slot_q;
    idx_d  = idx_q;
    par_d  = par_q;
    mode_d = mode_q;
    emit   = 1'b0;
    two    = 1'b0;
    w      = slot_q;
    tmp    = '0;
    t0a = w[0]; t0b = w[1]; t0c = w[2];
    t1a = w[0]; t1b = w[2]; t1c = w[3];
    if (accept) begin
      case (vtx_i.op)
        pa_pkg::OP_BEGIN: begin
          mode_d = vtx_i.prim_type;
          idx_d  = '0;
          par_d  = 1'b0;
        end
        pa_pkg::OP_END: begin
          mode_d = pa_pkg::MODE_NONE;
        end
        pa_pkg::OP_VERTEX: begin
          w[idx_q] = vtx_i.vertex_tag;
          slot_d   = w;
          t0a = w[0]; t0b = w[1]; t0c = w[2];
          t1a = w[0]; t1b = w[2]; t1c = w[3];
          case (mode_q)
            pa_pkg::TRIANGLES: begin
              if (idx_q == IW'(2)) begin
                emit  = 1'b1;
                idx_d = '0;
              end else begin
                idx_d = idx_q + IW'(1);
              end
            end
            pa_pkg::TRI_STRIP: begin
              if (idx_q == IW'(2)) begin
                emit = 1'b1;
                // flip orientation: retire the older of the first two slots
                if (par_q) begin
                  tmp       = slot_d[1];
                  slot_d[1] = slot_d[2];
                  slot_d[2] = tmp;
                end else begin
                  tmp       = slot_d[0];
                  slot_d[0] = slot_d[2];
                  slot_d[2] = tmp;
                end
                par_d = !par_q;
              end else begin
                idx_d = idx_q + IW'(1);
              end
            end
            pa_pkg::TRI_FAN: begin
              if (idx_q == IW'(2)) begin
                emit      = 1'b1;
                slot_d[1] = w[2];
                slot_d[2] = w[1];
              end else begin
                idx_d = idx_q + IW'(1);
              end
            end
            pa_pkg::QUADS: begin
              if (idx_q == IW'(3)) begin
                emit      = 1'b1;
                two       = 1'b1;
                slot_d[1] = w[2];
                slot_d[2] = w[3];
                slot_d[3] = w[1];
                idx_d     = '0;
              end else begin
                idx_d = idx_q + IW'(1);
              end
            end
            pa_pkg::QUAD_CHAIN: begin
              if (idx_q == IW'(3)) begin
                emit = 1'b1;
                two  = 1'b1;
                t0a = w[0]; t0b = w[1]; t0c = w[3];
                t1a = w[0]; t1b = w[3]; t1c = w[2];
                // keep the last two vertices as the first edge of the next quad
                slot_d[0] = w[2];
                slot_d[1] = w[3];
                slot_d[2] = w[0];
                slot_d[3] = w[1];
                idx_d     = IW'(2);
              end else begin
                idx_d = idx_q + IW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign run_push_o = accept && emit;
  assign run_data_o = {two, t1c, t1b, t1a, t0c, t0b, t0a};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '{default: '0};
      idx_q  <= '0;
      par_q  <= 1'b0;
      mode_q <= pa_pkg::MODE_NONE;
    end else begin
      slot_q <= slot_d;
      idx_q  <= idx_d;
      par_q  <= par_d;
      mode_q <= mode_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && vtx_i.op == pa_pkg::OP_BEGIN |=> idx_q == '0 && !par_q)
    else $error("begin did not clear slot index and parity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_push_o |-> vtx_i.op == pa_pkg::OP_VERTEX &&
      (mode_q == pa_pkg::TRIANGLES || mode_q == pa_pkg::TRI_STRIP ||
       mode_q == pa_pkg::TRI_FAN || mode_q == pa_pkg::QUADS ||
       mode_q == pa_pkg::QUAD_CHAIN))
    else $error("run pushed outside a primitive");

endmodule

@@ rtl/pa_fifo.sv @@
module pa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = pa_pkg::RUN_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full run queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty run queue");

endmodule

@@ rtl/pa_back.sv @@
module pa_back #(
  parameter int unsigned TAG_BITS = pa_pkg::TAG_BITS,
  localparam int unsigned RUN_W   = 6 * TAG_BITS + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [RUN_W-1:0] run_data_i,
  input  logic             run_empty_i,
  output logic             run_pop_o,
  pa_tri_if.source         tri_o
);

  logic                out_valid_q, out_last_q;
  logic [TAG_BITS-1:0] out_a_q, out_b_q, out_c_q;
  logic                sec_q;
  logic [TAG_BITS-1:0] sec_a_q, sec_b_q, sec_c_q;

  logic                two;
  logic [TAG_BITS-1:0] t0a, t0b, t0c, t1a, t1b, t1c;
  logic                slot_free;

  assign {two, t1c, t1b, t1a, t0c, t0b, t0a} = run_data_i;

  assign slot_free = !out_valid_q || tri_o.ready;
  assign run_pop_o = slot_free && !sec_q && !run_empty_i;

  assign tri_o.valid       = out_valid_q;
  assign tri_o.corner_a    = out_a_q;
  assign tri_o.corner_b    = out_b_q;
  assign tri_o.corner_c    = out_c_q;
  assign tri_o.last_of_run = out_last_q;

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (sec_q) begin
        out_a_q <= sec_a_q;
        out_b_q <= sec_b_q;
        out_c_q <= sec_c_q;
      end else begin
        out_a_q <= t0a;
        out_b_q <= t0b;
        out_c_q <= t0c;
        sec_a_q <= t1a;
        sec_b_q <= t1b;
        sec_c_q <= t1c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      sec_q       <= 1'b0;
    end else if (slot_free) begin
      if (sec_q) begin
        // send the second triangle of a quad
        out_valid_q <= 1'b1;
        out_last_q  <= 1'b1;
        sec_q       <= 1'b0;
      end else begin
        out_valid_q <= !run_empty_i;
        out_last_q  <= !two;
        sec_q       <= !run_empty_i && two;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q |-> out_valid_q && !out_last_q)
    else $error("second triangle pending without its first beat on the port");

endmodule

@@ rtl/primitive_assembly.sv @@
// Triangle assembly for a vertex stream. Begin beats pick the primitive mode
// (triangles, strip, fan, quads, quad strip), end beats return to none, and vertex
// beats fill a four-entry slot cache; each completed primitive leaves as one or two
// triangle beats, the final one flagged last_of_run. One input beat is taken every
// cycle while the four-run queue between the assembly front and the output stage
// has room. The output stage sends one triangle per cycle while tri_o is ready; a
// completing quad or quad-strip vertex occupies it for both triangles, the next run
// waiting. A triangle goes from the run queue into the output register to the port.
module primitive_assembly #(
  parameter int unsigned TAG_BITS = pa_pkg::TAG_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pa_vtx_if.sink   vtx_i,
  pa_tri_if.source tri_o
);

  localparam int unsigned RUN_W = 6 * TAG_BITS + 1;

  logic             run_push, run_pop, run_full, run_empty;
  logic [RUN_W-1:0] run_wdata, run_rdata;

  pa_front #(.TAG_BITS(TAG_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vtx_i      (vtx_i),
    .run_full_i (run_full),
    .run_push_o (run_push),
    .run_data_o (run_wdata)
  );

  pa_fifo #(.WIDTH(RUN_W), .DEPTH(pa_pkg::RUN_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (run_push),
    .wdata_i (run_wdata),
    .pop_i   (run_pop),
    .rdata_o (run_rdata),
    .full_o  (run_full),
    .empty_o (run_empty)
  );

  pa_back #(.TAG_BITS(TAG_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_data_i  (run_rdata),
    .run_empty_i (run_empty),
    .run_pop_o   (run_pop),
    .tri_o       (tri_o)
  );

endmodule
